// ===== sv/mpu_region_table_unit_macros.svh =====
// Assertion macros shared by the region table modules.
`ifndef MPU_REGION_TABLE_UNIT_MACROS_SVH
`define MPU_REGION_TABLE_UNIT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define MPURT_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// A condition that must be followed by a consequence in the next cycle.
`define MPURT_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/mpurt_pkg.sv =====
`default_nettype none
package mpurt_pkg;

  localparam logic MODE_CONFIG = 1'b0;
  localparam logic MODE_LOOKUP = 1'b1;

  localparam int unsigned MIN_BITS = 8;
  localparam int unsigned EXP_W    = 6;

  localparam logic [31:0] ATTR_NORMAL       = 32'h0008_0000;
  localparam logic [31:0] ATTR_XN           = 32'h1000_0000;
  localparam logic [31:0] ATTR_ENABLE       = 32'h0000_0001;
  localparam logic [31:0] BASE_VALID        = 32'h0000_0010;
  localparam logic [31:0] BASE_ADDR_MASK    = 32'hFFFF_FFE0;
  localparam logic [31:0] BASE_REGION_MASK  = 32'h0000_000F;

  localparam logic [2:0] ACC_NONE_NONE = 3'd0;
  localparam logic [2:0] ACC_RO_NONE   = 3'd1;
  localparam logic [2:0] ACC_RO_RO     = 3'd2;
  localparam logic [2:0] ACC_RW_NONE   = 3'd3;
  localparam logic [2:0] ACC_RW_RO     = 3'd4;
  localparam logic [2:0] ACC_RW_RW     = 3'd5;

  localparam logic [2:0] AP_NO_ACCESS = 3'd0;
  localparam logic [2:0] AP_PRIV_RW   = 3'd1;
  localparam logic [2:0] AP_PRIV_RW_RO = 3'd2;
  localparam logic [2:0] AP_FULL      = 3'd3;
  localparam logic [2:0] AP_PRIV_RO   = 3'd5;
  localparam logic [2:0] AP_READ_ONLY = 3'd6;

  typedef struct packed {
    logic        mode;
    logic [2:0]  region_index;
    logic [31:0] address;
    logic [31:0] length;
    logic [2:0]  access_code;
    logic        executable;
  } req_t;

  typedef struct packed {
    logic        hit;
    logic [2:0]  found_index;
    logic [31:0] attr_word;
    logic [31:0] base_word;
    logic [2:0]  found_access;
    logic [31:0] found_start;
    logic [31:0] found_end;
  } rsp_t;

  typedef struct packed {
    logic capture;
    logic calc_exp;
    logic calc_align;
    logic write_entry;
    logic scan_step;
    logic load_cfg;
    logic load_hit;
    logic load_miss;
  } cmd_t;

  typedef struct packed {
    logic match;
    logic last;
  } sts_t;

  function automatic logic [2:0] ap_of_code(input logic [2:0] code);
    logic [2:0] ap;
    case (code)
      ACC_NONE_NONE: ap = AP_NO_ACCESS;
      ACC_RO_NONE:   ap = AP_PRIV_RO;
      ACC_RO_RO:     ap = AP_READ_ONLY;
      ACC_RW_NONE:   ap = AP_PRIV_RW;
      ACC_RW_RO:     ap = AP_PRIV_RW_RO;
      ACC_RW_RW:     ap = AP_FULL;
      default:       ap = AP_NO_ACCESS;
    endcase
    return ap;
  endfunction

endpackage
`default_nettype wire

// ===== sv/mpurt_ctrl.sv =====
`default_nettype none
module mpurt_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire logic          mode_i,
  input  wire mpurt_pkg::sts_t sts_i,
  output mpurt_pkg::cmd_t    cmd_o,
  output logic               busy,
  output logic               done_o
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CFG_EXP,
    ST_CFG_ALIGN,
    ST_CFG_WRITE,
    ST_SCAN
  } state_e;

  state_e          state_q, state_d;
  logic            done_q, done_d;
  mpurt_pkg::cmd_t cmd;

  always_comb begin
    cmd     = '0;
    state_d = state_q;
    done_d  = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd.capture = 1'b1;
          state_d = (mode_i == mpurt_pkg::MODE_LOOKUP) ? ST_SCAN : ST_CFG_EXP;
        end
      end
      ST_CFG_EXP: begin
        cmd.calc_exp = 1'b1;
        state_d = ST_CFG_ALIGN;
      end
      ST_CFG_ALIGN: begin
        cmd.calc_align = 1'b1;
        state_d = ST_CFG_WRITE;
      end
      ST_CFG_WRITE: begin
        cmd.write_entry = 1'b1;
        cmd.load_cfg = 1'b1;
        done_d = 1'b1;
        state_d = ST_IDLE;
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts_i.match) begin
          cmd.load_hit = 1'b1;
          done_d = 1'b1;
          state_d = ST_IDLE;
        end else if (sts_i.last) begin
          cmd.load_miss = 1'b1;
          done_d = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      done_q  <= done_d;
    end
  end

  assign cmd_o  = cmd;
  assign busy   = (state_q != ST_IDLE);
  assign done_o = done_q;

`include "mpu_region_table_unit_macros.svh"

  `MPURT_ASSERT(a_done_follows_work, clk_i, rst_ni, done_q |-> $past(state_q != ST_IDLE), "Result strobe without a request in progress.")
  `MPURT_ASSERT_NEXT(a_accept_sets_busy, clk_i, rst_ni, start && !busy, busy, "Accepted request did not make the block busy.")
  `MPURT_ASSERT(a_single_result_load, clk_i, rst_ni, $onehot0({cmd.load_cfg, cmd.load_hit, cmd.load_miss}), "More than one result load in a cycle.")

endmodule
`default_nettype wire

// ===== sv/mpurt_datapath.sv =====
`default_nettype none
module mpurt_datapath #(
  parameter int unsigned NUM_REGIONS = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire mpurt_pkg::cmd_t cmd_i,
  input  wire mpurt_pkg::req_t req_i,
  output mpurt_pkg::sts_t      sts_o,
  output mpurt_pkg::rsp_t      rsp_o
);

  localparam int unsigned IdxW   = (NUM_REGIONS > 1) ? $clog2(NUM_REGIONS) : 1;
  localparam int unsigned AboveW = 32 - mpurt_pkg::MIN_BITS;
  localparam int unsigned ExpW   = mpurt_pkg::EXP_W;

  mpurt_pkg::req_t req_q;
  mpurt_pkg::rsp_t rsp_q, rsp_d;

  logic [31:0]      start_q  [NUM_REGIONS];
  logic [31:0]      end_q    [NUM_REGIONS];
  logic [2:0]       access_q [NUM_REGIONS];
  logic [31:0]      attr_q   [NUM_REGIONS];

  logic [ExpW-1:0]  exp_q, exp_d;
  logic [31:0]      st_q, st_d;
  logic [IdxW-1:0]  scan_idx_q, scan_idx_d;

  logic [31:0]      len_m1;
  logic [AboveW-1:0] above;
  logic [31:0]      mask;
  logic [31:0]      aligned;
  logic [31:0]      cfg_attr;
  logic [31:0]      cfg_end;
  logic             idx_ok;
  logic [IdxW+2:0]  wr_ext;
  logic [IdxW-1:0]  wr_idx;
  logic [IdxW+2:0]  scan_ext;
  logic [31:0]      sel_start;
  logic [31:0]      sel_end;
  logic             match;

  always_comb begin
    len_m1 = req_q.length - 32'd1;
    for (int e = mpurt_pkg::MIN_BITS; e < 32; e++) begin
      above[e - mpurt_pkg::MIN_BITS] = ((len_m1 >> e) != 32'd0);
    end
    if (req_q.length == 32'd0) begin
      exp_d = ExpW'(mpurt_pkg::MIN_BITS);
    end else begin
      exp_d = ExpW'(mpurt_pkg::MIN_BITS) + ExpW'($countones(above));
    end
  end

  always_comb begin
    if (exp_q >= ExpW'(32)) begin
      mask = '1;
    end else begin
      mask = (32'd1 << exp_q) - 32'd1;
    end
    if ((req_q.address & mask) != 32'd0) begin
      aligned = (req_q.address | mask) + 32'd1;
    end else begin
      aligned = req_q.address;
    end
    st_d = aligned & mpurt_pkg::BASE_ADDR_MASK;
  end

  always_comb begin
    cfg_attr = (32'(mpurt_pkg::ap_of_code(req_q.access_code)) << 24)
             | (req_q.executable ? 32'd0 : mpurt_pkg::ATTR_XN)
             | mpurt_pkg::ATTR_ENABLE
             | (32'(exp_q - ExpW'(1)) << 1)
             | mpurt_pkg::ATTR_NORMAL;
    cfg_end  = st_q + req_q.length;
    idx_ok   = (32'(req_q.region_index) < NUM_REGIONS);
    wr_ext   = (IdxW + 3)'(req_q.region_index);
    wr_idx   = wr_ext[IdxW-1:0];
  end

  always_comb begin
    sel_start = start_q[scan_idx_q];
    sel_end   = end_q[scan_idx_q];
    match     = (sel_start <= req_q.address) && (req_q.address < sel_end);
    scan_ext  = (IdxW + 3)'(scan_idx_q);
  end

  always_comb begin
    scan_idx_d = scan_idx_q;
    if (cmd_i.capture) begin
      scan_idx_d = IdxW'(NUM_REGIONS - 1);
    end else if (cmd_i.scan_step && !match) begin
      scan_idx_d = scan_idx_q - IdxW'(1);
    end
  end

  always_comb begin
    rsp_d = rsp_q;
    if (cmd_i.load_cfg) begin
      if (idx_ok) begin
        rsp_d.hit          = 1'b1;
        rsp_d.found_index  = req_q.region_index;
        rsp_d.attr_word    = cfg_attr;
        rsp_d.base_word    = st_q | mpurt_pkg::BASE_VALID | 32'(req_q.region_index);
        rsp_d.found_access = req_q.access_code;
        rsp_d.found_start  = st_q;
        rsp_d.found_end    = cfg_end;
      end else begin
        rsp_d = '0;
      end
    end else if (cmd_i.load_hit) begin
      rsp_d.hit          = 1'b1;
      rsp_d.found_index  = scan_ext[2:0];
      rsp_d.attr_word    = attr_q[scan_idx_q];
      rsp_d.base_word    = (sel_start & mpurt_pkg::BASE_ADDR_MASK) | mpurt_pkg::BASE_VALID
                         | (32'(scan_idx_q) & mpurt_pkg::BASE_REGION_MASK);
      rsp_d.found_access = access_q[scan_idx_q];
      rsp_d.found_start  = sel_start;
      rsp_d.found_end    = sel_end;
    end else if (cmd_i.load_miss) begin
      rsp_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_REGIONS; i++) begin
        start_q[i]  <= '0;
        end_q[i]    <= '0;
        access_q[i] <= '0;
        attr_q[i]   <= '0;
      end
      scan_idx_q <= '0;
    end else begin
      scan_idx_q <= scan_idx_d;
      if (cmd_i.write_entry && idx_ok) begin
        start_q[wr_idx]  <= st_q;
        end_q[wr_idx]    <= cfg_end;
        access_q[wr_idx] <= req_q.access_code;
        attr_q[wr_idx]   <= cfg_attr;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q <= req_i;
    end
    if (cmd_i.calc_exp) begin
      exp_q <= exp_d;
    end
    if (cmd_i.calc_align) begin
      st_q <= st_d;
    end
    rsp_q <= rsp_d;
  end

  assign sts_o.match = match;
  assign sts_o.last  = (scan_idx_q == '0);
  assign rsp_o       = rsp_q;

`include "mpu_region_table_unit_macros.svh"

  `MPURT_ASSERT_NEXT(a_scan_steps_down, clk_i, rst_ni, cmd_i.scan_step && !match && !sts_o.last, scan_idx_q == ($past(scan_idx_q) - IdxW'(1)), "Scan pointer did not move to the next lower entry.")
  `MPURT_ASSERT_NEXT(a_hit_loaded, clk_i, rst_ni, cmd_i.load_hit, rsp_q.hit, "Matched lookup did not report a hit.")
  `MPURT_ASSERT_NEXT(a_miss_clears, clk_i, rst_ni, cmd_i.load_miss, rsp_q == '0, "Lookup miss left result fields set.")

endmodule
`default_nettype wire

// ===== sv/mpu_region_table_unit.sv =====
// Channel   Handshake             Payload
// request   start high, busy low  req_i  (mpurt_pkg::req_t)
// result    done_o for one cycle  rsp_o  (mpurt_pkg::rsp_t)
//
// A configure request steps through the exponent, alignment and table write states
// of the controller; done_o is registered from the table write step.
// A lookup request scans one entry a cycle from the highest index down and stops at
// the first matching entry, or after entry 0 on a miss.
// Reset clears all table entries at once; no clearing pass follows.
// busy is high from acceptance until the result cycle, when a new request may be taken.
// The receiver cannot stall; rsp_o holds each result from its done_o cycle until the next result.
`default_nettype none
module mpu_region_table_unit #(
  parameter int unsigned NUM_REGIONS = 8
) (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            start,
  output logic                 busy,
  input  wire mpurt_pkg::req_t req_i,
  output logic                 done_o,
  output mpurt_pkg::rsp_t      rsp_o
);

  mpurt_pkg::cmd_t cmd;
  mpurt_pkg::sts_t sts;

  mpurt_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .mode_i (req_i.mode),
    .sts_i  (sts),
    .cmd_o  (cmd),
    .busy   (busy),
    .done_o (done_o)
  );

  mpurt_datapath #(
    .NUM_REGIONS (NUM_REGIONS)
  ) u_datapath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd),
    .req_i  (req_i),
    .sts_o  (sts),
    .rsp_o  (rsp_o)
  );

endmodule
`default_nettype wire
